// ===== hdl/lbr_pkg.sv =====
`default_nettype none

package lbr_pkg;

   localparam int LANES      = 3;
   localparam int DIV_STEPS  = 8;
   // Four stages of blend, one divider set-up stage and the divider steps.
   localparam int PIPE_DEPTH = 5 + DIV_STEPS;

   localparam logic [7:0] MAX8 = 8'd255;

   localparam logic CSR_SOURCE_OPACITY = 1'b0;
   localparam logic CSR_TARGET_OPACITY = 1'b1;

   // Alpha values that the lanes need at the stages where they use them.
   typedef struct packed {
      logic [7:0] sa1;
      logic [7:0] da1;
      logic [7:0] sa2;
      logic [7:0] da2;
      logic [7:0] ra4;
   } alpha_type;

   // round(a*b/255). The divide by 255 is done as (x + 1 + (x >> 8)) >> 8,
   // which is exact while the quotient stays at or below 255.
   function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] x;
      logic [15:0] y;
      x = ({8'd0, a} * {8'd0, b}) + 16'd127;
      y = x + 16'd1 + (x >> 8);
      return y[15:8];
   endfunction

   function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? MAX8 : s[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lighten_blend_rgba8_top.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_src_*, req_dst_* (8 bits each)
// rsp       out        rsp_valid/rsp_stall  rsp_out_red/green/blue/alpha
// csr       in         csr_write_en         csr_index, csr_wdata
//
// One item is taken every clock while req_stall is low.
// Most of the pipeline is the per-lane restoring divider, one quotient bit per stage.
// A skid register behind the output register absorbs one result; req_stall is
// registered and rises only when both hold a result.
// Reset empties the pipeline and sets both opacities to 255.
`default_nettype none

module lighten_blend_rgba8_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_src_red,
   input  wire logic [7:0] req_src_green,
   input  wire logic [7:0] req_src_blue,
   input  wire logic [7:0] req_src_alpha,
   input  wire logic [7:0] req_dst_red,
   input  wire logic [7:0] req_dst_green,
   input  wire logic [7:0] req_dst_blue,
   input  wire logic [7:0] req_dst_alpha,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_out_red,
   output logic      [7:0] rsp_out_green,
   output logic      [7:0] rsp_out_blue,
   output logic      [7:0] rsp_out_alpha,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int D = lbr_pkg::PIPE_DEPTH;

   logic [7:0] src_opacity_ff, dst_opacity_ff;
   logic       en;
   logic [D:1] valid_ff;

   logic [7:0] src_c [0:lbr_pkg::LANES-1];
   logic [7:0] dst_c [0:lbr_pkg::LANES-1];
   logic [7:0] src_c1_ff [0:lbr_pkg::LANES-1];
   logic [7:0] dst_c1_ff [0:lbr_pkg::LANES-1];
   logic [7:0] lane_out [0:lbr_pkg::LANES-1];

   logic [7:0] sa1_ff, da1_ff, sa2_ff, da2_ff, sada2_ff;
   logic [8:0] ra3_in;
   logic [7:0] ra_ff [3:D];
   lbr_pkg::alpha_type alpha;

   logic [31:0] fin_data, out_data_ff, skid_data_ff;
   logic        out_valid_ff, skid_full_ff, out_free;

   assign src_c[0] = req_src_red;
   assign src_c[1] = req_src_green;
   assign src_c[2] = req_src_blue;
   assign dst_c[0] = req_dst_red;
   assign dst_c[1] = req_dst_green;
   assign dst_c[2] = req_dst_blue;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_opacity_ff <= lbr_pkg::MAX8;
         dst_opacity_ff <= lbr_pkg::MAX8;
      end else if (csr_write_en) begin
         case (csr_index)
            lbr_pkg::CSR_SOURCE_OPACITY: src_opacity_ff <= csr_wdata;
            lbr_pkg::CSR_TARGET_OPACITY: dst_opacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[D-1:1], req_valid};
      end
   end

   assign ra3_in = {1'b0, sa2_ff} + {1'b0, da2_ff} - {1'b0, sada2_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         sa1_ff   <= lbr_pkg::mul8(req_src_alpha, src_opacity_ff);
         da1_ff   <= lbr_pkg::mul8(req_dst_alpha, dst_opacity_ff);
         sa2_ff   <= sa1_ff;
         da2_ff   <= da1_ff;
         sada2_ff <= lbr_pkg::mul8(sa1_ff, da1_ff);
         ra_ff[3] <= ra3_in[7:0];
         for (int i = 4; i <= D; i++) begin
            ra_ff[i] <= ra_ff[i-1];
         end
         for (int l = 0; l < lbr_pkg::LANES; l++) begin
            src_c1_ff[l] <= src_c[l];
            dst_c1_ff[l] <= dst_c[l];
         end
      end
   end

   assign alpha = '{sa1: sa1_ff, da1: da1_ff, sa2: sa2_ff, da2: da2_ff, ra4: ra_ff[4]};

   for (genvar l = 0; l < lbr_pkg::LANES; l++) begin : g_lane
      lbr_lane u_lane (
         .clock  (clock),
         .en     (en),
         .src_c  (src_c1_ff[l]),
         .dst_c  (dst_c1_ff[l]),
         .alpha  (alpha),
         .result (lane_out[l])
      );
   end

   // Merge the lanes and the alpha into one result word.
   assign fin_data = {lane_out[0], lane_out[1], lane_out[2], ra_ff[D]};
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end
      end else if (valid_ff[D]) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (out_free) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (valid_ff[D]) begin
         if (out_free) begin
            out_data_ff <= fin_data;
         end else begin
            skid_data_ff <= fin_data;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_data_ff[31:24];
   assign rsp_out_green = out_data_ff[23:16];
   assign rsp_out_blue  = out_data_ff[15:8];
   assign rsp_out_alpha = out_data_ff[7:0];

endmodule

`default_nettype wire

// ===== hdl/lbr_div.sv =====
`default_nettype none

// Un-premultiply: min(255, (c*255 + a/2) / a), or 0 when a is 0.
// One set-up stage, then one quotient bit per stage.
module lbr_div (
   input  wire logic       clock,
   input  wire logic       en,
   input  wire logic [7:0] color,
   input  wire logic [7:0] alpha,
   output logic      [7:0] quot
);

   logic [15:0] rem_ff  [0:lbr_pkg::DIV_STEPS];
   logic [7:0]  den_ff  [0:lbr_pkg::DIV_STEPS];
   logic [7:0]  quot_ff [0:lbr_pkg::DIV_STEPS];
   logic        sat_ff  [0:lbr_pkg::DIV_STEPS];
   logic        zero_ff [0:lbr_pkg::DIV_STEPS];

   logic [15:0] num_in;

   assign num_in = ({color, 8'h00} - {8'h00, color}) + {9'h000, alpha[7:1]};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= alpha;
         quot_ff[0] <= '0;
         // A quotient of 256 or more saturates.
         sat_ff[0]  <= num_in >= {alpha, 8'h00};
         zero_ff[0] <= alpha == 8'd0;
      end
   end

   for (genvar k = 0; k < lbr_pkg::DIV_STEPS; k++) begin : g_step
      logic [15:0] trial;
      logic        ge;
      logic [15:0] rem_in;
      logic [7:0]  quot_in;

      always_comb begin
         trial   = 16'({8'h00, den_ff[k]} << (lbr_pkg::DIV_STEPS - 1 - k));
         ge      = rem_ff[k] >= trial;
         rem_in  = ge ? rem_ff[k] - trial : rem_ff[k];
         quot_in = quot_ff[k] | (ge ? 8'(1 << (lbr_pkg::DIV_STEPS - 1 - k)) : 8'd0);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_ff[k];
            quot_ff[k+1] <= quot_in;
            sat_ff[k+1]  <= sat_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   always_comb begin
      if (zero_ff[lbr_pkg::DIV_STEPS]) begin
         quot = 8'd0;
      end else if (sat_ff[lbr_pkg::DIV_STEPS]) begin
         quot = lbr_pkg::MAX8;
      end else begin
         quot = quot_ff[lbr_pkg::DIV_STEPS];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lbr_lane.sv =====
`default_nettype none

// One colour channel: premultiply, lighten select, then un-premultiply.
module lbr_lane (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [7:0]             src_c,
   input  wire logic [7:0]             dst_c,
   input  wire lbr_pkg::alpha_type     alpha,
   output logic      [7:0]             result
);

   logic [7:0] sc2_ff, dc2_ff;
   logic [7:0] sc3_ff, dc3_ff;
   logic [7:0] sd3_ff, ds3_ff, dinv3_ff, sinv3_ff;
   logic [7:0] res4_ff;
   logic [7:0] res4_in;

   always_comb begin
      if (sd3_ff > ds3_ff) begin
         res4_in = lbr_pkg::add8(sc3_ff, dinv3_ff);
      end else begin
         res4_in = lbr_pkg::add8(dc3_ff, sinv3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc2_ff   <= lbr_pkg::mul8(src_c, alpha.sa1);
         dc2_ff   <= lbr_pkg::mul8(dst_c, alpha.da1);
         sc3_ff   <= sc2_ff;
         dc3_ff   <= dc2_ff;
         sd3_ff   <= lbr_pkg::mul8(sc2_ff, alpha.da2);
         ds3_ff   <= lbr_pkg::mul8(dc2_ff, alpha.sa2);
         dinv3_ff <= lbr_pkg::mul8(dc2_ff, lbr_pkg::MAX8 - alpha.sa2);
         sinv3_ff <= lbr_pkg::mul8(sc2_ff, lbr_pkg::MAX8 - alpha.da2);
         res4_ff  <= res4_in;
      end
   end

   lbr_div u_div (
      .clock (clock),
      .en    (en),
      .color (res4_ff),
      .alpha (alpha.ra4),
      .quot  (result)
   );

endmodule

`default_nettype wire

// ===== hdl/lbr_checker.sv =====
`default_nettype none

module lbr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_red,
   input wire logic [7:0] rsp_out_green,
   input wire logic [7:0] rsp_out_blue,
   input wire logic [7:0] rsp_out_alpha
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_red) && $stable(rsp_out_green)
                                 && $stable(rsp_out_blue) && $stable(rsp_out_alpha))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // A transparent composite carries no colour.
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_alpha == 8'd0 |->
         rsp_out_red == 8'd0 && rsp_out_green == 8'd0 && rsp_out_blue == 8'd0)
      else $error("colour set on zero alpha");

   // The input side only stalls once a result is held back at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

bind lighten_blend_rgba8_top lbr_checker u_lbr_checker (.*);

`default_nettype wire
